/* hdl/dgm_pkg.sv */
// Package of the depth gradient map: constants, types and the sequencer states.
`default_nettype none
package dgm_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int HALF_SLOTS = (MAX_WIDTH + 1) / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(HALF_SLOTS);
    localparam int QUO_W      = 31;
    localparam int STEP_W     = $clog2(QUO_W + 1);

    localparam logic [2:0] REG_ROW_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HALF_RES   = 3'd1;
    localparam logic [2:0] REG_GRAD_OFF   = 3'd2;
    localparam logic [2:0] REG_STEEP_THR  = 3'd3;
    localparam logic [2:0] REG_STEEP_VAL  = 3'd4;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_STEEP = 2'd2;

    typedef struct packed {
        logic [1:0]  sy;
        logic [15:0] gy;
        logic [1:0]  sx;
        logic [15:0] gx;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_PREP, S_DIV, S_FIN, S_OUT
    } t_state;
endpackage
`default_nettype wire

/* hdl/dgm_stream_if.sv */
// Valid/ready stream interface carrying one item of payload.
`default_nettype none
interface dgm_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/depth_gradient_map_top.sv */
// Top level of the depth gradient map: sequencer, shared divider and line stores.
`default_nettype none
// One restoring divider, producing one quotient bit per cycle, is shared by the
// X and Y gradients, 31 steps each. A computing pixel item passes through the
// line-store read, then per gradient through operand set-up, 31 divider steps
// and a finishing step, then through the step that forms the result. A gradient
// with no usable neighbour, or with a zero depth or neighbour, skips its divider
// steps. Replica pixels in half-resolution mode skip the divider and go from the
// line-store read straight to forming the result. The block takes one item at a
// time and is ready again the cycle after its result register is loaded, while
// that result still waits. A result that has not been taken holds the sequencer
// in its last step. Input payload is {end_of_frame, depth}; output payload is
// {y_maximum, y_minimum, x_maximum, x_minimum, y_status, grad_y, x_status,
// grad_x}. After reset both line stores are cleared by a pass over the MAX_WIDTH
// (1024) column addresses, during which no item is taken.
module depth_gradient_map_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dgm_stream_if.sink   i_pix,
    dgm_stream_if.source o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import dgm_pkg::*;

    // Configuration registers.
    logic [10:0] r_row_width;
    logic        r_half;
    logic [15:0] r_offset;
    logic [14:0] r_thr;
    logic [15:0] r_steep;
    logic [2:0]  w_reg;
    assign w_reg  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 11'd640;
            r_half      <= 1'b1;
            r_offset    <= '0;
            r_thr       <= 15'd16384;
            r_steep     <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_ROW_WIDTH: r_row_width <= pwdata[10:0];
                REG_HALF_RES:  r_half      <= pwdata[0];
                REG_GRAD_OFF:  r_offset    <= pwdata[15:0];
                REG_STEEP_THR: r_thr       <= pwdata[14:0];
                REG_STEEP_VAL: r_steep     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ROW_WIDTH: prdata = {21'd0, r_row_width};
            REG_HALF_RES:  prdata = {31'd0, r_half};
            REG_GRAD_OFF:  prdata = {16'd0, r_offset};
            REG_STEEP_THR: prdata = {17'd0, r_thr};
            REG_STEEP_VAL: prdata = {16'd0, r_steep};
            default:       prdata = '0;
        endcase
    end

    // Effective width clamped into two to MAX_WIDTH.
    logic [COL_W:0] eff_w;
    always_comb begin
        if (r_row_width < 11'd2) eff_w = (COL_W+1)'(2);
        else if ({1'b0, r_row_width} > 12'(MAX_WIDTH)) eff_w = (COL_W+1)'(MAX_WIDTH);
        else eff_w = (COL_W+1)'(r_row_width);
    end

    // Stream position and neighbour state.
    logic [COL_W-1:0] r_col;
    logic             r_parity, r_started;
    logic [15:0]      r_left1, r_left2;
    t_res             r_held;
    logic signed [15:0] r_xmin, r_xmax, r_ymin, r_ymax;

    // Line stores, cleared by a pass over MAX_WIDTH addresses after reset.
    logic [15:0] upper_mem [MAX_WIDTH];
    t_res anchor_mem [HALF_SLOTS];
    logic [15:0] r_upper_q;
    t_res        r_anchor_q;
    logic             r_clearing;
    logic [COL_W-1:0] r_clr;

    // Current item.
    logic [15:0]      r_d;
    logic             r_eof;
    logic [COL_W-1:0] r_x;
    logic [SLOT_W-1:0] slot;
    assign slot = SLOT_W'(r_x >> 1);

    // Shared divider: restoring, one quotient bit per cycle.
    logic [QUO_W-1:0] r_quo;
    logic [16:0]      r_rem, r_div;
    logic [STEP_W-1:0] r_step;
    logic             r_axis;   // 0 = X pass, 1 = Y pass
    logic             r_neg, r_have;
    logic [16:0]      r_mag;
    logic [17:0]      trial;
    logic [17:0]      rem_sh;
    logic             num_bit;
    assign num_bit = (r_step >= 5'd14) ? r_mag[5'(r_step - 5'd14)] : 1'b0;
    assign rem_sh  = {r_rem, num_bit};
    assign trial   = rem_sh - {1'b0, r_div};

    t_res   r_res;
    t_state r_state, n_state;
    logic [99:0]  r_out;
    logic         r_out_vld;
    logic         out_free;

    // The result register can be loaded when it is empty or being emptied.
    assign out_free    = !r_out_vld || o_res.ready;
    assign i_pix.ready = (r_state == S_IDLE) && !r_clearing;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    logic pix_acc;
    assign pix_acc = i_pix.valid && i_pix.ready;

    // Neighbour selection for the current pass.
    logic [15:0] nb;
    logic        have_nb;
    always_comb begin
        if (!r_axis) begin
            nb      = r_half ? r_left2 : r_left1;
            have_nb = r_half ? (r_x > COL_W'(1)) : (r_x != '0);
        end else begin
            nb      = r_upper_q;
            have_nb = r_started;
        end
    end

    logic replica, compute;
    assign replica = r_half && (r_parity || r_x[0]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (pix_acc) n_state = S_READ;
            S_READ: n_state = replica ? S_OUT : S_PREP;
            S_PREP: n_state = (have_nb && r_d != '0 && nb != '0) ? S_DIV : S_FIN;
            S_DIV:  if (r_step == '0) n_state = S_FIN;
            S_FIN:  n_state = r_axis ? S_OUT : S_PREP;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign compute = 1'b1;

    // Memories: registered reads, single write port each.
    always_ff @(posedge i_clk) begin
        r_upper_q  <= upper_mem[r_x];
        r_anchor_q <= anchor_mem[slot];
        if (r_clearing) begin
            upper_mem[r_clr]              <= '0;
            anchor_mem[r_clr[SLOT_W-1:0]] <= '0;
        end else if (r_state == S_OUT && out_free) begin
            if (compute && !(r_half && r_parity))
                upper_mem[r_x] <= r_d;
            if (r_half && !r_parity && !r_x[0])
                anchor_mem[slot] <= r_res;
        end
    end

    logic signed [16:0] sq;
    assign sq = r_neg ? -$signed({2'b00, r_quo[14:0]}) : $signed({2'b00, r_quo[14:0]});
    logic steep_q;
    assign steep_q = r_quo > QUO_W'(r_thr);

    logic [COL_W:0] x_next;
    assign x_next = {1'b0, r_x} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_parity <= 1'b0; r_started <= 1'b0;
            r_left1 <= '0; r_left2 <= '0; r_held <= '0;
            r_xmin <= 16'sd32767; r_xmax <= -16'sd32768;
            r_ymin <= 16'sd32767; r_ymax <= -16'sd32768;
            r_out_vld <= 1'b0;
            r_clearing <= 1'b1; r_clr <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == COL_W'(MAX_WIDTH - 1)) r_clearing <= 1'b0;
            end
            if (o_res.valid && o_res.ready && !(r_state == S_OUT && out_free))
                r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: if (pix_acc) begin
                    r_d   <= i_pix.data[15:0];
                    r_eof <= i_pix.data[16];
                    r_x   <= ({1'b0, r_col} >= eff_w) ? COL_W'(eff_w - 1'b1) : r_col;
                end
                S_READ: begin
                    r_axis <= 1'b0;
                    r_res  <= '0;
                end
                S_PREP: begin
                    r_neg  <= nb > r_d;
                    r_mag  <= {1'b0, (nb > r_d) ? nb - r_d : r_d - nb};
                    r_div  <= {1'b0, r_d} + {1'b0, r_offset};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_step <= STEP_W'(QUO_W - 1);
                    r_have <= have_nb && r_d != '0 && nb != '0;
                end
                S_DIV: begin
                    if (!trial[17]) begin
                        r_rem <= trial[16:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[16:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    r_step <= r_step - 1'b1;
                end
                S_FIN: begin
                    r_axis <= 1'b1;
                    if (r_have) begin
                        if (steep_q) begin
                            if (!r_axis) begin r_res.gx <= r_steep; r_res.sx <= ST_STEEP; end
                            else begin r_res.gy <= r_steep; r_res.sy <= ST_STEEP; end
                        end else if (!r_axis) begin
                            r_res.gx <= sq[15:0]; r_res.sx <= ST_RANGE;
                            if ($signed(sq[15:0]) > r_xmax) r_xmax <= sq[15:0];
                            if ($signed(sq[15:0]) < r_xmin) r_xmin <= sq[15:0];
                        end else begin
                            r_res.gy <= sq[15:0]; r_res.sy <= ST_RANGE;
                            if ($signed(sq[15:0]) > r_ymax) r_ymax <= sq[15:0];
                            if ($signed(sq[15:0]) < r_ymin) r_ymin <= sq[15:0];
                        end
                    end
                end
                S_OUT: begin
                    t_res res_v;
                    res_v = r_res;
                    if (replica) begin
                        if (r_parity) res_v = r_anchor_q;
                        else          res_v = r_held;
                    end
                    if (out_free) begin
                        if (r_half && !r_parity && !r_x[0]) r_held <= r_res;
                        r_out <= {r_ymax, r_ymin, r_xmax, r_xmin, res_v};
                        r_out_vld <= 1'b1;
                        r_left2 <= r_left1;
                        r_left1 <= r_d;
                        if (r_eof) begin
                            r_col <= '0; r_parity <= 1'b0; r_started <= 1'b0;
                            r_xmin <= 16'sd32767; r_xmax <= -16'sd32768;
                            r_ymin <= 16'sd32767; r_ymax <= -16'sd32768;
                        end else if (x_next >= eff_w) begin
                            r_col <= '0; r_parity <= !r_parity; r_started <= 1'b1;
                        end else begin
                            r_col <= x_next[COL_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The divisor is never zero, because only a nonzero depth starts a division.
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div != '0) else $error("divider by zero");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_out_vld) else $error("result not presented");
endmodule
`default_nettype wire
